/* sv/fbe_pkg.sv */
// ----------------------------------------------------------------------------
// fbe_pkg
// Shared widths, register codes and types of the flush backpressure estimator.
// ----------------------------------------------------------------------------
package fbe_pkg;

    localparam int REQ_W      = 32;
    localparam int INT_W      = 32;
    localparam int BYTE_W     = 48;
    localparam int THR_W      = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;
    localparam int HALF_W     = BYTE_W / 2;
    localparam int PART_W     = HALF_W + INT_W;
    localparam int WIDE_W     = BYTE_W + INT_W;

    typedef enum logic [1:0] {
        REG_THRESHOLD   = 2'd0,
        REG_BYTE_BUDGET = 2'd1,
        REG_REQ_LIMIT   = 2'd2,
        REG_REQ_BYTES   = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [THR_W-1:0]  threshold;
        logic [BYTE_W-1:0] byte_budget;
        logic [THR_W-1:0]  req_limit;
        logic [BYTE_W-1:0] req_bytes;
    } t_cfg;

    typedef struct packed {
        logic              done;
        logic              flag;
        logic [INT_W-1:0]  ints;
    } t_side;

    typedef struct packed {
        t_side             side;
        logic [BYTE_W-1:0] bytes;
    } t_item;

endpackage

/* sv/fbe_if.sv */
// ----------------------------------------------------------------------------
// fbe_in_if / fbe_out_if
// Valid/ready channels for input items and results.
// ----------------------------------------------------------------------------
interface fbe_in_if;
    logic                       valid;
    logic                       ready;
    logic [fbe_pkg::REQ_W-1:0]  pending_requests;
    logic [fbe_pkg::INT_W-1:0]  interval_count;
    logic [fbe_pkg::BYTE_W-1:0] cached_bytes;
    modport source (output valid, pending_requests, interval_count, cached_bytes,
                    input ready);
    modport sink (input valid, pending_requests, interval_count, cached_bytes,
                  output ready);
endinterface

interface fbe_out_if;
    logic valid;
    logic ready;
    logic backpressure;
    modport source (output valid, backpressure, input ready);
    modport sink (input valid, backpressure, output ready);
endinterface

/* sv/fbe_cfg.sv */
// ----------------------------------------------------------------------------
// fbe_cfg
// APB register file holding the four estimator settings.
// ----------------------------------------------------------------------------
module fbe_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fbe_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [fbe_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [fbe_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output fbe_pkg::t_cfg                  o_cfg,
    output logic                           o_wr
);
    fbe_pkg::t_cfg     r_cfg;
    fbe_pkg::t_cfg_reg w_idx;
    logic              w_wr;

    assign w_idx  = fbe_pkg::t_cfg_reg'(paddr[4:3]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;
    assign o_wr   = w_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            case (w_idx)
                fbe_pkg::REG_THRESHOLD:   r_cfg.threshold   <= pwdata[31:0];
                fbe_pkg::REG_BYTE_BUDGET: r_cfg.byte_budget <= pwdata[47:0];
                fbe_pkg::REG_REQ_LIMIT:   r_cfg.req_limit   <= pwdata[31:0];
                fbe_pkg::REG_REQ_BYTES:   r_cfg.req_bytes   <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            fbe_pkg::REG_THRESHOLD:   prdata = {32'b0, r_cfg.threshold};
            fbe_pkg::REG_BYTE_BUDGET: prdata = {16'b0, r_cfg.byte_budget};
            fbe_pkg::REG_REQ_LIMIT:   prdata = {32'b0, r_cfg.req_limit};
            fbe_pkg::REG_REQ_BYTES:   prdata = {16'b0, r_cfg.req_bytes};
            default:                  prdata = '0;
        endcase
    end
endmodule

/* sv/fbe_queue.sv */
// ----------------------------------------------------------------------------
// fbe_queue
// Two-entry queue between the classifier and the divider pipeline.
// ----------------------------------------------------------------------------
module fbe_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fbe_pkg::t_item i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output fbe_pkg::t_item o_data
);
    fbe_pkg::t_item r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
endmodule

/* sv/fbe_front.sv */
// ----------------------------------------------------------------------------
// fbe_front
// Takes input transfers, marks trivial and byte-budget cases settled, queues all.
// ----------------------------------------------------------------------------
module fbe_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fbe_pkg::t_cfg  i_cfg,
    input  logic           i_cfg_wr,
    fbe_in_if.sink         i_in,
    input  logic           i_full,
    output logic           o_push,
    output fbe_pkg::t_item o_item
);
    logic [fbe_pkg::PART_W-1:0] r_td_lo;
    logic [fbe_pkg::PART_W-1:0] r_td_hi;
    logic [fbe_pkg::WIDE_W-1:0] w_td;
    logic                       w_zero;
    logic                       w_hit;
    logic                       r_cfg_wr;

    // threshold * byte budget, in two partial products
    always_ff @(posedge i_clk) begin
        r_td_lo <= fbe_pkg::PART_W'(i_cfg.threshold) *
                   fbe_pkg::PART_W'(i_cfg.byte_budget[fbe_pkg::HALF_W-1:0]);
        r_td_hi <= fbe_pkg::PART_W'(i_cfg.threshold) *
                   fbe_pkg::PART_W'(i_cfg.byte_budget[fbe_pkg::BYTE_W-1:fbe_pkg::HALF_W]);
    end

    // products are registered and so lag a register write; hold input off meanwhile
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_wr <= 1'b0;
        end else begin
            r_cfg_wr <= i_cfg_wr;
        end
    end

    assign w_td = {r_td_hi, {fbe_pkg::HALF_W{1'b0}}} + fbe_pkg::WIDE_W'(r_td_lo);

    assign w_zero = (i_cfg.threshold == '0) || (i_in.pending_requests <= i_cfg.threshold)
                 || (i_in.cached_bytes == '0) || (i_in.interval_count == '0);
    assign w_hit  = (i_cfg.byte_budget != '0)
                 && (fbe_pkg::WIDE_W'(i_in.cached_bytes) > w_td);

    assign i_in.ready      = !i_full && !r_cfg_wr;
    assign o_push          = i_in.valid && !i_full && !r_cfg_wr;
    assign o_item.side.done = w_zero || w_hit || (i_cfg.req_limit == '0);
    assign o_item.side.flag = !w_zero && w_hit;
    assign o_item.side.ints = i_in.interval_count;
    assign o_item.bytes     = i_in.cached_bytes;
endmodule

/* sv/fbe_div.sv */
// ----------------------------------------------------------------------------
// fbe_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module fbe_div #(
    parameter int NW = 48,
    parameter int DW = 32,
    parameter int SW = 34
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic          o_rem_nz,
    output logic [SW-1:0] o_side
);
    logic          r_v  [NW];
    logic [DW-1:0] r_r  [NW];
    logic [NW-1:0] r_nq [NW];
    logic [DW-1:0] r_d  [NW];
    logic [SW-1:0] r_s  [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          w_v;
        logic [DW-1:0] w_r;
        logic [NW-1:0] w_nq;
        logic [DW-1:0] w_d;
        logic [SW-1:0] w_s;
        logic [DW:0]   w_t;
        logic [DW:0]   w_sub;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_v  = i_valid;
            assign w_r  = '0;
            assign w_nq = i_num;
            assign w_d  = i_den;
            assign w_s  = i_side;
        end else begin : g_next
            assign w_v  = r_v[k-1];
            assign w_r  = r_r[k-1];
            assign w_nq = r_nq[k-1];
            assign w_d  = r_d[k-1];
            assign w_s  = r_s[k-1];
        end

        assign w_t   = {w_r, w_nq[NW-1]};
        assign w_sub = w_t - {1'b0, w_d};
        assign w_ge  = (w_t >= {1'b0, w_d});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[k]  <= w_ge ? w_sub[DW-1:0] : w_t[DW-1:0];
                r_nq[k] <= {w_nq[NW-2:0], w_ge};
                r_d[k]  <= w_d;
                r_s[k]  <= w_s;
            end
        end
    end

    assign o_valid  = r_v[NW-1];
    assign o_quo    = r_nq[NW-1];
    assign o_rem_nz = (r_r[NW-1] != '0);
    assign o_side   = r_s[NW-1];
endmodule

/* sv/fbe_back.sv */
// ----------------------------------------------------------------------------
// fbe_back
// Request-count estimate: two divider pipelines, product and final compare.
// ----------------------------------------------------------------------------
module fbe_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fbe_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    input  fbe_pkg::t_item i_item,
    output logic           o_pop,
    fbe_out_if.source      o_out
);
    localparam int SW = $bits(fbe_pkg::t_side);

    logic                          w_en;
    logic                          w_a_v;
    logic [fbe_pkg::BYTE_W-1:0]    w_a_q;
    logic                          w_a_nz;
    logic [SW-1:0]                 w_a_s;
    logic                          r_c1_v;
    logic [fbe_pkg::BYTE_W-1:0]    r_c1_per;
    logic [SW-1:0]                 r_c1_s;
    logic [fbe_pkg::BYTE_W-1:0]    w_den_b;
    logic                          w_b_v;
    logic [fbe_pkg::BYTE_W-1:0]    w_b_q;
    logic                          w_b_nz;
    logic [SW-1:0]                 w_b_s;
    fbe_pkg::t_side                w_b_side;
    logic [fbe_pkg::BYTE_W-1:0]    w_pieces;
    logic                          r_c2_v;
    logic [fbe_pkg::PART_W-1:0]    r_ph;
    logic [fbe_pkg::PART_W-1:0]    r_pl;
    fbe_pkg::t_side                r_c2_s;
    logic [2*fbe_pkg::THR_W-1:0]   r_tr;
    logic [fbe_pkg::WIDE_W-1:0]    w_total;
    logic                          r_out_v;
    logic                          r_out_bp;

    assign w_en  = !r_out_v || o_out.ready;
    assign o_pop = w_en && i_valid;

    fbe_div #(.NW(fbe_pkg::BYTE_W), .DW(fbe_pkg::INT_W), .SW(SW)) u_div_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(i_valid),
        .i_num(i_item.bytes), .i_den(i_item.side.ints), .i_side(SW'(i_item.side)),
        .o_valid(w_a_v), .o_quo(w_a_q), .o_rem_nz(w_a_nz), .o_side(w_a_s)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_v <= 1'b0;
        end else if (w_en) begin
            r_c1_v <= w_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1_per <= w_a_q + fbe_pkg::BYTE_W'(w_a_nz);
            r_c1_s   <= w_a_s;
        end
    end

    assign w_den_b = (i_cfg.req_bytes == '0) ? fbe_pkg::BYTE_W'(1) : i_cfg.req_bytes;

    fbe_div #(.NW(fbe_pkg::BYTE_W), .DW(fbe_pkg::BYTE_W), .SW(SW)) u_div_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_c1_v),
        .i_num(r_c1_per), .i_den(w_den_b), .i_side(r_c1_s),
        .o_valid(w_b_v), .o_quo(w_b_q), .o_rem_nz(w_b_nz), .o_side(w_b_s)
    );

    assign w_b_side = fbe_pkg::t_side'(w_b_s);
    assign w_pieces = (i_cfg.req_bytes == '0) ? fbe_pkg::BYTE_W'(1)
                                              : w_b_q + fbe_pkg::BYTE_W'(w_b_nz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2_v <= 1'b0;
        end else if (w_en) begin
            r_c2_v <= w_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ph   <= fbe_pkg::PART_W'(w_pieces[fbe_pkg::BYTE_W-1:fbe_pkg::HALF_W]) *
                      fbe_pkg::PART_W'(w_b_side.ints);
            r_pl   <= fbe_pkg::PART_W'(w_pieces[fbe_pkg::HALF_W-1:0]) *
                      fbe_pkg::PART_W'(w_b_side.ints);
            r_c2_s <= w_b_side;
        end
        r_tr <= (2*fbe_pkg::THR_W)'(i_cfg.threshold) * (2*fbe_pkg::THR_W)'(i_cfg.req_limit);
    end

    assign w_total = {r_ph, {fbe_pkg::HALF_W{1'b0}}} + fbe_pkg::WIDE_W'(r_pl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= r_c2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_bp <= r_c2_s.done ? r_c2_s.flag : (w_total > fbe_pkg::WIDE_W'(r_tr));
        end
    end

    assign o_out.valid        = r_out_v;
    assign o_out.backpressure = r_out_bp;
endmodule

/* sv/flush_backpressure_estimator.sv */
// ----------------------------------------------------------------------------
// flush_backpressure_estimator
// Flags backpressure when the estimated flush batch count exceeds a threshold.
// ----------------------------------------------------------------------------
// One item per cycle while the output register is not stalled, one result per
// item. A result passes through the queue, two 48-stage divider pipelines (bytes
// per interval, then pieces per request), a rounding stage, a product stage and
// the output register. A two-entry queue separates the classifier from the
// pipeline; the whole pipeline stalls only while the output register holds a
// result not yet taken. Input is held off after each register write while the
// threshold products settle.
module flush_backpressure_estimator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    fbe_in_if.sink                         i_in,
    fbe_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fbe_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [fbe_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [fbe_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    fbe_pkg::t_cfg  w_cfg;
    logic           w_cfg_wr;
    logic           w_push;
    logic           w_full;
    fbe_pkg::t_item w_item;
    logic           w_q_valid;
    fbe_pkg::t_item w_q_item;
    logic           w_pop;

    fbe_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .o_cfg(w_cfg), .o_wr(w_cfg_wr)
    );

    fbe_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(w_cfg), .i_cfg_wr(w_cfg_wr),
        .i_in(i_in), .i_full(w_full), .o_push(w_push), .o_item(w_item)
    );

    fbe_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_data(w_item),
        .o_full(w_full), .i_pop(w_pop), .o_valid(w_q_valid), .o_data(w_q_item)
    );

    fbe_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(w_cfg), .i_valid(w_q_valid),
        .i_item(w_q_item), .o_pop(w_pop), .o_out(o_out)
    );
endmodule
